>>> design/bdq_pkg.sv
// Package for the bounded deque with search: sizes, request and status
// codes, and the sequencer state type. No dependencies.
package bdq_pkg;

	localparam int DEPTH   = 64;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = 7;
	localparam int REQ_W   = 3;
	localparam int STAT_W  = 2;
	localparam int WORD_W  = 32;
	localparam int REC_W   = 2 * WORD_W;
	localparam int OUT_W   = 72;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH_FRONT = 3'd0,
		REQ_POP_FRONT  = 3'd1,
		REQ_PUSH_BACK  = 3'd2,
		REQ_POP_BACK   = 3'd3,
		REQ_FIND       = 3'd4
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_POP,
		S_SCAN,
		S_OUT
	} state_t;

endpackage

>>> design/bounded_deque_with_search_unit.sv
// Top level of the bounded deque with search: ring-buffer record store,
// request sequencer and output register. Depends on bdq_pkg.
//
// Requests arrive on the s_ channel: s_tuser carries the request kind
// (push front, pop front, push back, pop back, find by code), s_tdata the
// record code and weight. Each request yields one result on the m_ channel:
// m_tuser carries the status, m_tdata the returned record, the entry count
// after the request and an empty flag.
// Requests are handled one at a time; s_tready is high only while idle.
// A pop makes one registered read of the record store. A find walks the
// stored records from the front through the one comparator, one record a
// cycle, and stops at the first match or after the last record; the single
// read port of the store sets that rate.
// The result sits in an output register; while the receiver stalls it holds,
// the next request may be taken and worked on, and its result waits until
// the register is freed.
// Reset clears the head index, the count, the sequencer and the output
// valid; the store is not cleared, as only held records are ever read.
module bounded_deque_with_search_unit
	import bdq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [REC_W-1:0]  s_tdata,  // [31:0] item_code, [63:32] item_weight
	input  logic [REQ_W-1:0]  s_tuser,  // [2:0] req_type
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,  // [31:0] out_code, [63:32] out_weight,
	                                    // [70:64] entry_total, [71] is_empty
	output logic [STAT_W-1:0] m_tuser   // [1:0] status
);

	state_t             state_q, state_d;
	logic [REQ_W-1:0]   req_q;
	logic [WORD_W-1:0]  code_q;
	logic [WORD_W-1:0]  weight_q;
	logic [IDX_W-1:0]   head_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   idx_q;

	logic [REC_W-1:0]   mem [DEPTH];
	logic [REC_W-1:0]   rd_data_q;
	logic               wr_en, rd_en;
	logic [IDX_W-1:0]   wr_addr, rd_addr;

	logic [STAT_W-1:0]  res_status_q;
	logic [REC_W-1:0]   res_rec_q;
	logic [STAT_W-1:0]  out_status_q;
	logic [REC_W-1:0]   out_rec_q;
	logic [CNT_W-1:0]   out_count_q;
	logic               m_tvalid_q;

	logic               full, empty, match, scan_last, out_free;
	logic [IDX_W-1:0]   head_dec;
	logic [CNT_W-1:0]   idx_next;

	function automatic logic [IDX_W-1:0] ring(input logic [IDX_W-1:0] head,
	                                          input logic [IDX_W-1:0] off);
		logic [IDX_W:0] sum;
		sum = {1'b0, head} + {1'b0, off};
		if (sum >= (IDX_W+1)'(DEPTH))
			sum = sum - (IDX_W+1)'(DEPTH);
		return sum[IDX_W-1:0];
	endfunction

	assign full      = (count_q >= CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign head_dec  = (head_q == '0) ? IDX_W'(DEPTH - 1) : head_q - IDX_W'(1);
	assign match     = (rd_data_q[WORD_W-1:0] == code_q);
	assign idx_next  = CNT_W'(idx_q) + CNT_W'(1);
	assign scan_last = (idx_next == count_q);
	assign out_free  = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = head_dec;
		rd_en    = 1'b0;
		rd_addr  = head_q;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid)
					state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_OUT;
				case (req_q)
					REQ_PUSH_FRONT: begin
						wr_en   = !full;
						wr_addr = head_dec;
					end
					REQ_PUSH_BACK: begin
						wr_en   = !full;
						wr_addr = ring(head_q, count_q[IDX_W-1:0]);
					end
					REQ_POP_FRONT: begin
						rd_en   = !empty;
						rd_addr = head_q;
						if (!empty)
							state_d = S_POP;
					end
					REQ_POP_BACK: begin
						rd_en   = !empty;
						rd_addr = ring(head_q, IDX_W'(count_q - CNT_W'(1)));
						if (!empty)
							state_d = S_POP;
					end
					REQ_FIND: begin
						rd_en   = !empty;
						rd_addr = head_q;
						if (!empty)
							state_d = S_SCAN;
					end
					default: ;
				endcase
			end
			S_POP: begin
				state_d = S_OUT;
			end
			S_SCAN: begin
				// compare the record read last cycle, fetch the next one
				if (match || scan_last) begin
					state_d = S_OUT;
				end else begin
					rd_en   = 1'b1;
					rd_addr = ring(head_q, idx_next[IDX_W-1:0]);
				end
			end
			S_OUT: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// record store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= {weight_q, code_q};
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			req_q    <= s_tuser;
			code_q   <= s_tdata[WORD_W-1:0];
			weight_q <= s_tdata[REC_W-1:WORD_W];
		end
		unique case (state_q)
			S_EXEC: begin
				res_rec_q <= '0;
				idx_q     <= '0;
				case (req_q)
					REQ_PUSH_FRONT, REQ_PUSH_BACK:
						res_status_q <= full ? ST_FULL : ST_OK;
					REQ_POP_FRONT, REQ_POP_BACK, REQ_FIND:
						res_status_q <= empty ? ST_EMPTY : ST_OK;
					default:
						res_status_q <= ST_OK;
				endcase
			end
			S_POP: begin
				res_rec_q <= rd_data_q;
			end
			S_SCAN: begin
				idx_q <= idx_next[IDX_W-1:0];
				if (match) begin
					res_rec_q    <= rd_data_q;
					res_status_q <= ST_OK;
				end else if (scan_last) begin
					res_status_q <= ST_NOTFOUND;
				end
			end
			default: ;
		endcase
		if (state_q == S_OUT && out_free) begin
			out_status_q <= res_status_q;
			out_rec_q    <= res_rec_q;
			out_count_q  <= count_q;
		end
	end

	// ring pointers and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == S_EXEC) begin
				case (req_q)
					REQ_PUSH_FRONT: begin
						if (!full) begin
							head_q  <= head_dec;
							count_q <= count_q + CNT_W'(1);
						end
					end
					REQ_PUSH_BACK: begin
						if (!full)
							count_q <= count_q + CNT_W'(1);
					end
					REQ_POP_FRONT: begin
						if (!empty) begin
							head_q  <= ring(head_q, IDX_W'(1));
							count_q <= count_q - CNT_W'(1);
						end
					end
					REQ_POP_BACK: begin
						if (!empty)
							count_q <= count_q - CNT_W'(1);
					end
					default: ;
				endcase
			end
			if (state_q == S_OUT && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {(out_count_q == '0), out_count_q, out_rec_q};

endmodule

>>> test/tb.sv
// Self-checking bench for bounded_deque_with_search_unit: a directed table, then phased
// random requests, scored against replies fixed in the table or a behavioural deque
// kept in the bench. Depends on bdq_pkg and the unit itself.
`timescale 1ns / 100ps

module tb;
	import bdq_pkg::*;

	localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd5;
	localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;
	localparam int RANDOM_ITEMS   = 1150;
	localparam int PLAN_ROWS      = 23;
	localparam int LONG_HOLD      = 300;
	localparam int HOLD_AT_FIRST  = 30;
	localparam int HOLD_AT_SECOND = 650;
	localparam int SETTLE_CYCLES  = DEPTH + 16;
	localparam int MAX_PRINTED    = 50;

	typedef struct packed {
		status_t             status;
		logic [WORD_W-1:0]   code;
		logic [WORD_W-1:0]   weight;
		logic [CNT_W-1:0]    total;
		logic                empty;
	} reply_t;

	typedef struct packed {
		logic [REQ_W-1:0]  kind;
		logic [WORD_W-1:0] code;
		logic [WORD_W-1:0] weight;
		logic              fixed;  // expected reply given in the row
		reply_t            want;
	} plan_row_t;

	typedef enum {MODE_FILL, MODE_MIXED, MODE_DRAIN} mix_mode_t;

	localparam reply_t FROM_MODEL = '0;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [REC_W-1:0]  s_tdata = '0;  // [31:0] item_code, [63:32] item_weight
	logic [REQ_W-1:0]  s_tuser = '0;  // [2:0] req_type
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;       // [31:0] out_code, [63:32] out_weight,
	                                  // [70:64] entry_total, [71] is_empty
	logic [STAT_W-1:0] m_tuser;       // [1:0] status

	// behavioural copy of the deque
	logic [WORD_W-1:0] store_code [DEPTH];
	logic [WORD_W-1:0] store_weight [DEPTH];
	int                front_slot = 0;
	int                held_count = 0;

	reply_t    awaited_replies [$];
	int        mismatches = 0;
	int        src_calm = 0;
	int        sink_calm = 0;
	plan_row_t plan [PLAN_ROWS];

	bounded_deque_with_search_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	function automatic reply_t apply_request(input logic [REQ_W-1:0] kind,
			input logic [WORD_W-1:0] code, input logic [WORD_W-1:0] weight);
		reply_t r;
		int     slot;
		int     i;
		r = '0;
		r.status = ST_OK;
		case (kind)
			REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
				if (held_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					if (kind == REQ_PUSH_FRONT) begin
						front_slot = (front_slot + DEPTH - 1) % DEPTH;
						slot = front_slot;
					end else begin
						slot = (front_slot + held_count) % DEPTH;
					end
					store_code[slot] = code;
					store_weight[slot] = weight;
					held_count++;
				end
			end
			REQ_POP_FRONT, REQ_POP_BACK: begin
				if (held_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					slot = (kind == REQ_POP_FRONT) ? front_slot
						: (front_slot + held_count - 1) % DEPTH;
					r.code = store_code[slot];
					r.weight = store_weight[slot];
					if (kind == REQ_POP_FRONT)
						front_slot = (front_slot + 1) % DEPTH;
					held_count--;
				end
			end
			REQ_FIND: begin
				if (held_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					// first match counted from the front wins
					r.status = ST_NOTFOUND;
					for (i = 0; i < held_count && r.status == ST_NOTFOUND; i++) begin
						slot = (front_slot + i) % DEPTH;
						if (store_code[slot] == code) begin
							r.code = store_code[slot];
							r.weight = store_weight[slot];
							r.status = ST_OK;
						end
					end
				end
			end
			default: ;
		endcase
		r.total = CNT_W'(held_count);
		r.empty = (held_count == 0);
		return r;
	endfunction

	function automatic int draw_gap(inout int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm_left = $urandom_range(15, 50);
			return 0;
		end
		return $urandom_range(0, 12);
	endfunction

	// a few codes that recur, so finds hit duplicates and extremes
	function automatic logic [WORD_W-1:0] pool_code(input int k);
		case (k)
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'hFFFF_FFFF;
			3:       return 32'h0000_0000;
			4:       return 32'h0000_0001;
			5:       return 32'h5A5A_A5A5;
			6:       return 32'h0000_0100;
			default: return 32'hC0DE_0001;
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < MAX_PRINTED)
			$display("%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic compare_field(input int n, input string name,
			input logic [WORD_W-1:0] got, input logic [WORD_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("reply %0d %s: got %h, expected %h", n, name, got, want));
	endtask

	// Drive one request, hold it until transferred, then record the reply it must cause.
	task automatic offer(input logic [REQ_W-1:0] kind, input logic [WORD_W-1:0] code,
			input logic [WORD_W-1:0] weight, input logic fixed, input reply_t want);
		int     gap;
		reply_t modelled;
		gap = draw_gap(src_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {weight, code};
		do @(posedge clk); while (!s_tready);
		modelled = apply_request(kind, code, weight);
		awaited_replies.push_back(fixed ? want : modelled);
	endtask

	task automatic run_random();
		int                issued;
		int                left;
		int                pick;
		int                push_cut;
		int                pop_cut;
		logic              back_side;
		logic              go_up;
		mix_mode_t         mode;
		logic [REQ_W-1:0]  kind;
		logic [WORD_W-1:0] code;
		logic [WORD_W-1:0] weight;
		issued = 0;
		mode = MODE_FILL;
		left = -1;
		go_up = 1'b0;
		while (issued < RANDOM_ITEMS) begin
			// fill and drain run until the bound is hit, then linger a little
			if (left == 0) begin
				if (mode == MODE_MIXED) begin
					mode = go_up ? MODE_FILL : MODE_DRAIN;
					left = -1;
				end else begin
					go_up = (mode == MODE_DRAIN);
					mode = MODE_MIXED;
					left = $urandom_range(30, 120);
				end
			end
			if (left < 0 && ((mode == MODE_FILL && held_count == DEPTH)
					|| (mode == MODE_DRAIN && held_count == 0)))
				left = $urandom_range(2, 12);

			case (mode)
				MODE_FILL: begin
					push_cut = 80;
					pop_cut = 90;
				end
				MODE_DRAIN: begin
					push_cut = 10;
					pop_cut = 90;
				end
				default: begin
					push_cut = 30;
					pop_cut = 60;
				end
			endcase
			back_side = $urandom_range(0, 1);
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 99) < 3)
				kind = REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
			else if (pick < push_cut)
				kind = back_side ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
			else if (pick < pop_cut)
				kind = back_side ? REQ_POP_BACK : REQ_POP_FRONT;
			else
				kind = REQ_FIND;

			pick = $urandom_range(0, 99);
			if (kind == REQ_FIND && held_count > 0 && pick < 60)
				code = store_code[(front_slot + $urandom_range(0, held_count - 1)) % DEPTH];
			else if ((kind == REQ_FIND || kind == REQ_PUSH_FRONT || kind == REQ_PUSH_BACK)
					&& pick < 85)
				code = pool_code($urandom_range(0, 7));
			else
				code = $urandom;

			case ($urandom_range(0, 15))
				0:       weight = '0;
				1:       weight = '1;
				default: weight = $urandom;
			endcase

			offer(kind, code, weight, 1'b0, FROM_MODEL);
			if (kind <= REQ_FIND) begin
				issued++;
				if (left > 0)
					left--;
			end
		end
	endtask

	initial begin : request_source
		// kind, code, weight, fixed, then status, code, weight, total, empty when fixed
		plan = '{
			{REQ_POP_FRONT,  32'h0000_0000, 32'h0000_0000, 1'b1,
				ST_EMPTY, 32'h0, 32'h0, 7'd0, 1'b1},
			{REQ_POP_BACK,   32'h0000_0000, 32'h0000_0000, 1'b1,
				ST_EMPTY, 32'h0, 32'h0, 7'd0, 1'b1},
			{REQ_FIND,       32'h0000_0000, 32'h0000_0000, 1'b1,
				ST_EMPTY, 32'h0, 32'h0, 7'd0, 1'b1},
			{REQ_SPARE_LO,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
				ST_OK,    32'h0, 32'h0, 7'd0, 1'b1},
			{REQ_PUSH_BACK,  32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1,
				ST_OK,    32'h0, 32'h0, 7'd1, 1'b0},
			{REQ_PUSH_FRONT, 32'h8000_0000, 32'h0000_0000, 1'b1,
				ST_OK,    32'h0, 32'h0, 7'd2, 1'b0},
			{REQ_PUSH_BACK,  32'hFFFF_FFFF, 32'h0000_0001, 1'b0, FROM_MODEL},
			{REQ_PUSH_FRONT, 32'h0000_0000, 32'h8000_0000, 1'b0, FROM_MODEL},
			{REQ_FIND,       32'h7FFF_FFFF, 32'h0000_0000, 1'b0, FROM_MODEL},
			{REQ_FIND,       32'h0000_0001, 32'h0000_0000, 1'b0, FROM_MODEL},
			{REQ_FIND,       32'hFFFF_FFFF, 32'h0000_0000, 1'b0, FROM_MODEL},
			{REQ_PUSH_BACK,  32'h0000_0000, 32'h3F80_0000, 1'b0, FROM_MODEL},
			{REQ_FIND,       32'h0000_0000, 32'hFFFF_FFFF, 1'b0, FROM_MODEL},
			{REQ_SPARE_HI,   32'h1234_5678, 32'h9ABC_DEF0, 1'b0, FROM_MODEL},
			{REQ_POP_BACK,   32'h0000_0000, 32'h0000_0000, 1'b0, FROM_MODEL},
			{REQ_POP_FRONT,  32'h0000_0000, 32'h0000_0000, 1'b0, FROM_MODEL},
			{REQ_POP_FRONT,  32'h0000_0000, 32'h0000_0000, 1'b0, FROM_MODEL},
			{REQ_POP_BACK,   32'h0000_0000, 32'h0000_0000, 1'b0, FROM_MODEL},
			{REQ_POP_BACK,   32'h0000_0000, 32'h0000_0000, 1'b0, FROM_MODEL},
			{REQ_POP_FRONT,  32'h0000_0000, 32'h0000_0000, 1'b1,
				ST_EMPTY, 32'h0, 32'h0, 7'd0, 1'b1},
			{REQ_FIND,       32'h8000_0000, 32'h0000_0000, 1'b1,
				ST_EMPTY, 32'h0, 32'h0, 7'd0, 1'b1},
			{REQ_PUSH_FRONT, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1,
				ST_OK,    32'h0, 32'h0, 7'd1, 1'b0},
			{REQ_POP_BACK,   32'h0000_0000, 32'h0000_0000, 1'b0, FROM_MODEL}
		};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		foreach (plan[r])
			offer(plan[r].kind, plan[r].code, plan[r].weight, plan[r].fixed, plan[r].want);
		run_random();
		s_tvalid <= 1'b0;
		while (awaited_replies.size() != 0)
			@(posedge clk);
		// leave room for a stray reply after the last awaited one
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("bounded_deque_with_search_unit: match");
		else
			$display("bounded_deque_with_search_unit: mismatch");
		$finish;
	end

	initial begin : reply_sink
		int     gap;
		int     seen;
		reply_t want;
		seen = 0;
		wait (arst_n);
		forever begin
			// twice, hold off long enough for the unit to back up and stall its input
			if (seen == HOLD_AT_FIRST || seen == HOLD_AT_SECOND)
				gap = LONG_HOLD;
			else
				gap = draw_gap(sink_calm);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (awaited_replies.size() == 0) begin
				report_mismatch($sformatf("reply %0d arrived with none awaited", seen));
			end else begin
				want = awaited_replies.pop_front();
				compare_field(seen, "status", WORD_W'(m_tuser), WORD_W'(want.status));
				compare_field(seen, "code", m_tdata[31:0], want.code);
				compare_field(seen, "weight", m_tdata[63:32], want.weight);
				compare_field(seen, "total", WORD_W'(m_tdata[70:64]), WORD_W'(want.total));
				compare_field(seen, "empty", WORD_W'(m_tdata[71]), WORD_W'(want.empty));
			end
			seen++;
		end
	end

	initial begin : watchdog
		#2_000_000;
		$display("bounded_deque_with_search_unit: mismatch");
		$finish;
	end

endmodule
